// ===== sv/ocu_pkg.sv =====
// ----------------------------------------------------------------------------
// Online covariance update package
// Shared widths, item type, back-end state type and saturation limits.
// ----------------------------------------------------------------------------
package ocu_pkg;

    localparam int MAX_VECTOR = 1024;
    localparam int ADDR_W     = $clog2(MAX_VECTOR);
    localparam int LEN_W      = 11;
    localparam int IDX_W      = 10;
    localparam int SAMP_W     = 32;
    localparam int COV_W      = 48;
    localparam int CNT_W      = 32;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    // Serial divider lengths: mean update and covariance update.
    localparam int MDIV_W   = SAMP_W + 1;
    localparam int CNUM_W   = 82;
    localparam int STEP_W   = 7;

    localparam logic [COV_W-1:0] COV_MAX = {1'b0, {(COV_W-1){1'b1}}};
    localparam logic [COV_W-1:0] COV_MIN = {1'b1, {(COV_W-1){1'b0}}};

    typedef struct packed {
        logic [SAMP_W-1:0] x;
        logic [SAMP_W-1:0] y;
        logic [IDX_W-1:0]  idx;
        logic              last;
        logic [CNT_W-1:0]  n;
        logic [CNT_W-1:0]  seen;
    } t_item;

    typedef enum logic [3:0] {
        S_IDLE, S_READ, S_LOAD, S_DIVM, S_MEAN, S_DIFF, S_MULD, S_MULL,
        S_MULH, S_ACC, S_NEG, S_ADD, S_ABS, S_DIVC, S_SAT, S_WRITE
    } t_bstate;

endpackage

// ===== sv/online_covariance_update.sv =====
// ----------------------------------------------------------------------------
// Online covariance update
// Per-element running sample covariance of two Q16.16 vector streams.
// ----------------------------------------------------------------------------
// Each accepted beat carries one element pair of the current sample vector
// and yields one result beat with the element's updated Q32.16 covariance,
// its position, the count of vectors seen including this one, and a flag on
// the last element. The front end tags elements with position and count as
// they arrive and queues up to four of them, so input beats are taken while
// the back end works. The back end handles one element at a time with the
// one-bit-per-cycle dividers (33 steps for the mean update, 82 steps for the
// covariance update), and skips the covariance update while the first vector
// is in progress. A finished result waits in an output register without
// blocking the next element. The stores read as zero until an element is
// first written, tracked by a fill count, so there is no clearing pass after
// reset. Write the vector length only while idle.
// ----------------------------------------------------------------------------
module online_covariance_update (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [ocu_pkg::LEN_W-1:0]  i_cfg_data,
    input  logic                       push,
    output logic                       full,
    input  logic [ocu_pkg::SAMP_W-1:0] i_sample_x,
    input  logic [ocu_pkg::SAMP_W-1:0] i_sample_y,
    output logic                       empty,
    input  logic                       pop,
    output logic [ocu_pkg::IDX_W-1:0]  o_element_index,
    output logic [ocu_pkg::COV_W-1:0]  o_covariance_value,
    output logic [ocu_pkg::CNT_W-1:0]  o_samples_seen,
    output logic                       o_vector_done
);
    import ocu_pkg::*;

    t_item front_item;
    t_item q_item;
    logic  q_empty;
    logic  q_pop;
    logic  accept;

    // An input beat lands when the queue has room.
    assign accept = push && !full;

    ocu_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_sample_x  (i_sample_x),
        .i_sample_y  (i_sample_y),
        .o_item      (front_item)
    );

    ocu_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_item  (front_item),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_item  (q_item),
        .o_empty (q_empty)
    );

    ocu_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_item             (q_item),
        .i_item_empty       (q_empty),
        .o_item_pop         (q_pop),
        .o_empty            (empty),
        .i_pop              (pop),
        .o_element_index    (o_element_index),
        .o_covariance_value (o_covariance_value),
        .o_samples_seen     (o_samples_seen),
        .o_vector_done      (o_vector_done)
    );

endmodule

// ===== sv/ocu_front.sv =====
// ----------------------------------------------------------------------------
// Online covariance front end
// Holds the vector length, tracks element position and sample count, and
// tags each accepted element for the back end.
// ----------------------------------------------------------------------------
module ocu_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [ocu_pkg::LEN_W-1:0]  i_cfg_data,
    input  logic                       i_accept,
    input  logic [ocu_pkg::SAMP_W-1:0] i_sample_x,
    input  logic [ocu_pkg::SAMP_W-1:0] i_sample_y,
    output ocu_pkg::t_item             o_item
);
    import ocu_pkg::*;

    logic [LEN_W-1:0] r_len;
    logic [IDX_W-1:0] r_pos;
    logic [CNT_W-1:0] r_count;
    logic [LEN_W-1:0] len_eff;
    logic [LEN_W-1:0] pos_inc;
    logic             last;
    logic [CNT_W-1:0] seen;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        if (r_len == '0) begin
            len_eff = LEN_W'(1);
        end else if (r_len > LEN_W'(MAX_VECTOR)) begin
            len_eff = LEN_W'(MAX_VECTOR);
        end else begin
            len_eff = r_len;
        end
        pos_inc = {{(LEN_W-IDX_W){1'b0}}, r_pos} + LEN_W'(1);
        last    = (pos_inc >= len_eff);
        seen    = (r_count == '1) ? r_count : r_count + CNT_W'(1);
    end

    assign o_item = '{x: i_sample_x, y: i_sample_y, idx: r_pos, last: last,
                      n: r_count, seen: seen};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len   <= LEN_W'(MAX_VECTOR);
            r_pos   <= '0;
            r_count <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_len <= i_cfg_data;
            end
            if (i_accept) begin
                if (last) begin
                    r_pos   <= '0;
                    r_count <= seen;
                end else begin
                    r_pos <= pos_inc[IDX_W-1:0];
                end
            end
        end
    end

endmodule

// ===== sv/ocu_fifo.sv =====
// ----------------------------------------------------------------------------
// Online covariance item queue
// Short queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module ocu_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ocu_pkg::t_item i_item,
    output logic           o_full,
    input  logic           i_pop,
    output ocu_pkg::t_item o_item,
    output logic           o_empty
);
    import ocu_pkg::*;

    t_item              r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wp;
    logic [FIFO_AW-1:0] r_rp;
    logic [FIFO_AW:0]   r_cnt;
    logic               do_push;
    logic               do_pop;

    assign o_full  = (r_cnt == (FIFO_AW+1)'(FIFO_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + FIFO_AW'(1);
            end
            if (do_pop) begin
                r_rp <= r_rp + FIFO_AW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + (FIFO_AW+1)'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - (FIFO_AW+1)'(1);
            end
        end
    end

endmodule

// ===== sv/ocu_back.sv =====
// ----------------------------------------------------------------------------
// Online covariance back end
// Per-element read-modify-write of the mean and covariance stores with
// bit-serial dividers, plus the result register.
// ----------------------------------------------------------------------------
module ocu_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  ocu_pkg::t_item             i_item,
    input  logic                       i_item_empty,
    output logic                       o_item_pop,
    output logic                       o_empty,
    input  logic                       i_pop,
    output logic [ocu_pkg::IDX_W-1:0]  o_element_index,
    output logic [ocu_pkg::COV_W-1:0]  o_covariance_value,
    output logic [ocu_pkg::CNT_W-1:0]  o_samples_seen,
    output logic                       o_vector_done
);
    import ocu_pkg::*;

    localparam int MEM_W = COV_W + 2 * SAMP_W;

    t_bstate r_state, n_state;

    logic [MEM_W-1:0]  r_mem [MAX_VECTOR];
    logic [MEM_W-1:0]  r_rd;
    logic              r_hit;
    logic [ADDR_W:0]   r_fill;

    t_item             r_item;
    logic [SAMP_W-1:0] r_mx, r_my;
    logic [COV_W-1:0]  r_cov;
    logic [MDIV_W-1:0] r_dvd_x, r_dvd_y, r_q_x, r_q_y, r_rem_x, r_rem_y, r_dsr;
    logic              r_sgn_x, r_sgn_y;
    logic [STEP_W-1:0] r_cnt;
    logic [SAMP_W-1:0] r_mxn, r_myn;
    logic [MDIV_W-1:0] r_adx, r_ady;
    logic              r_psgn, r_cneg;
    logic [COV_W-1:0]  r_cm;
    logic [65:0]       r_pdd;
    logic [63:0]       r_plo;
    logic [47:0]       r_phi;
    logic [79:0]       r_amag;
    logic [97:0]       r_a, r_b, r_s;
    logic [CNUM_W-1:0] r_cdv, r_cq;
    logic [CNT_W-1:0]  r_crem;
    logic [COV_W-1:0]  r_covn;

    logic              r_ovalid;
    logic [IDX_W-1:0]  r_oidx;
    logic [COV_W-1:0]  r_ocov;
    logic [CNT_W-1:0]  r_oseen;
    logic              r_odone;

    logic              out_free;
    logic              wr_en;
    logic [CNT_W-1:0]  m_fac;
    logic [MDIV_W:0]   sh_x, sh_y, dsr_ext;
    logic              ge_x, ge_y;
    logic [CNT_W:0]    sh_c;
    logic              ge_c;
    logic [SAMP_W-1:0] ld_mx, ld_my;
    logic [COV_W-1:0]  ld_cov;
    logic [MDIV_W-1:0] dmx, dmy, ddx, ddy;
    logic [MDIV_W:0]   qx_s, qy_s, mxn_s, myn_s;

    assign out_free = !r_ovalid || i_pop;
    assign wr_en    = (r_state == S_WRITE) && out_free;
    assign m_fac    = r_item.n - CNT_W'(1);

    always_comb begin
        ld_mx   = r_hit ? r_rd[2*SAMP_W-1:SAMP_W] : '0;
        ld_my   = r_hit ? r_rd[SAMP_W-1:0] : '0;
        ld_cov  = r_hit ? r_rd[MEM_W-1:2*SAMP_W] : '0;
        dmx     = {r_item.x[SAMP_W-1], r_item.x} - {ld_mx[SAMP_W-1], ld_mx};
        dmy     = {r_item.y[SAMP_W-1], r_item.y} - {ld_my[SAMP_W-1], ld_my};
        dsr_ext = {1'b0, r_dsr};
        sh_x    = {r_rem_x, r_dvd_x[MDIV_W-1]};
        sh_y    = {r_rem_y, r_dvd_y[MDIV_W-1]};
        ge_x    = (sh_x >= dsr_ext);
        ge_y    = (sh_y >= dsr_ext);
        sh_c    = {r_crem, r_cdv[CNUM_W-1]};
        ge_c    = (sh_c >= {1'b0, r_item.n});
        qx_s    = r_sgn_x ? -{1'b0, r_q_x} : {1'b0, r_q_x};
        qy_s    = r_sgn_y ? -{1'b0, r_q_y} : {1'b0, r_q_y};
        mxn_s   = {{2{r_mx[SAMP_W-1]}}, r_mx} + qx_s;
        myn_s   = {{2{r_my[SAMP_W-1]}}, r_my} + qy_s;
        ddx     = {r_item.x[SAMP_W-1], r_item.x} - {r_mxn[SAMP_W-1], r_mxn};
        ddy     = {r_item.y[SAMP_W-1], r_item.y} - {r_my[SAMP_W-1], r_my};
    end

    always_comb begin
        n_state    = r_state;
        o_item_pop = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (!i_item_empty) begin
                    o_item_pop = 1'b1;
                    n_state    = S_READ;
                end
            end
            S_READ:  n_state = S_LOAD;
            S_LOAD:  n_state = S_DIVM;
            S_DIVM:  if (r_cnt == STEP_W'(MDIV_W - 1)) n_state = S_MEAN;
            S_MEAN:  n_state = (r_item.n == '0) ? S_WRITE : S_DIFF;
            S_DIFF:  n_state = S_MULD;
            S_MULD:  n_state = S_MULL;
            S_MULL:  n_state = S_MULH;
            S_MULH:  n_state = S_ACC;
            S_ACC:   n_state = S_NEG;
            S_NEG:   n_state = S_ADD;
            S_ADD:   n_state = S_ABS;
            S_ABS:   n_state = S_DIVC;
            S_DIVC:  if (r_cnt == STEP_W'(CNUM_W - 1)) n_state = S_SAT;
            S_SAT:   n_state = S_WRITE;
            S_WRITE: if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_item.idx[ADDR_W-1:0]] <= {r_covn, r_mxn, r_myn};
        end
        r_rd <= r_mem[r_item.idx[ADDR_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_fill   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (wr_en) begin
                r_ovalid <= 1'b1;
                if ({1'b0, r_item.idx[ADDR_W-1:0]} >= r_fill) begin
                    r_fill <= {1'b0, r_item.idx[ADDR_W-1:0]} + (ADDR_W+1)'(1);
                end
            end else if (i_pop) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: r_item <= i_item;
            S_READ: r_hit <= ({1'b0, r_item.idx[ADDR_W-1:0]} < r_fill);
            S_LOAD: begin
                r_mx    <= ld_mx;
                r_my    <= ld_my;
                r_cov   <= ld_cov;
                r_sgn_x <= dmx[MDIV_W-1];
                r_sgn_y <= dmy[MDIV_W-1];
                r_dvd_x <= dmx[MDIV_W-1] ? -dmx : dmx;
                r_dvd_y <= dmy[MDIV_W-1] ? -dmy : dmy;
                r_rem_x <= '0;
                r_rem_y <= '0;
                r_dsr   <= {1'b0, r_item.n} + MDIV_W'(1);
                r_cnt   <= '0;
            end
            S_DIVM: begin
                r_dvd_x <= r_dvd_x << 1;
                r_dvd_y <= r_dvd_y << 1;
                r_rem_x <= ge_x ? MDIV_W'(sh_x - dsr_ext) : sh_x[MDIV_W-1:0];
                r_rem_y <= ge_y ? MDIV_W'(sh_y - dsr_ext) : sh_y[MDIV_W-1:0];
                r_q_x   <= {r_q_x[MDIV_W-2:0], ge_x};
                r_q_y   <= {r_q_y[MDIV_W-2:0], ge_y};
                r_cnt   <= r_cnt + STEP_W'(1);
            end
            S_MEAN: begin
                r_mxn  <= mxn_s[SAMP_W-1:0];
                r_myn  <= myn_s[SAMP_W-1:0];
                r_covn <= r_cov;
            end
            S_DIFF: begin
                r_adx  <= ddx[MDIV_W-1] ? -ddx : ddx;
                r_ady  <= ddy[MDIV_W-1] ? -ddy : ddy;
                r_psgn <= ddx[MDIV_W-1] ^ ddy[MDIV_W-1];
                r_cm   <= r_cov[COV_W-1] ? -r_cov : r_cov;
            end
            S_MULD: r_pdd <= r_adx * r_ady;
            S_MULL: r_plo <= m_fac * r_cm[31:0];
            S_MULH: r_phi <= m_fac * r_cm[47:32];
            S_ACC: begin
                r_amag <= {r_phi, 32'b0} + {16'b0, r_plo};
                r_b    <= r_psgn ? -{32'b0, r_pdd} : {32'b0, r_pdd};
            end
            S_NEG: begin
                r_a <= r_cov[COV_W-1] ? -{2'b0, r_amag, 16'b0} : {2'b0, r_amag, 16'b0};
            end
            S_ADD: r_s <= r_a + r_b;
            S_ABS: begin
                r_cneg <= r_s[97];
                r_cdv  <= r_s[97] ? CNUM_W'((-r_s) >> 16) : r_s[97:16];
                r_crem <= '0;
                r_cnt  <= '0;
            end
            S_DIVC: begin
                r_cdv  <= r_cdv << 1;
                r_crem <= ge_c ? CNT_W'(sh_c - {1'b0, r_item.n}) : sh_c[CNT_W-1:0];
                r_cq   <= {r_cq[CNUM_W-2:0], ge_c};
                r_cnt  <= r_cnt + STEP_W'(1);
            end
            S_SAT: begin
                if (r_cneg) begin
                    r_covn <= (r_cq > {{(CNUM_W-COV_W){1'b0}}, COV_MIN}) ? COV_MIN
                              : -r_cq[COV_W-1:0];
                end else begin
                    r_covn <= (r_cq > {{(CNUM_W-COV_W){1'b0}}, COV_MAX}) ? COV_MAX
                              : r_cq[COV_W-1:0];
                end
            end
            S_WRITE: begin
                if (out_free) begin
                    r_oidx  <= r_item.idx;
                    r_ocov  <= r_covn;
                    r_oseen <= r_item.seen;
                    r_odone <= r_item.last;
                end
            end
            default: ;
        endcase
    end

    assign o_empty            = !r_ovalid;
    assign o_element_index    = r_oidx;
    assign o_covariance_value = r_ocov;
    assign o_samples_seen     = r_oseen;
    assign o_vector_done      = r_odone;

`ifndef SYNTHESIS
    a_write_loads_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |=> r_ovalid)
        else $error("result register not loaded after store write");
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= (ADDR_W+1)'(MAX_VECTOR))
        else $error("fill count beyond store depth");
    a_divm_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIVM) |-> (r_cnt < STEP_W'(MDIV_W)))
        else $error("mean divider ran past its length");
    a_cov_skip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MEAN && r_item.n == '0) |=> (r_state == S_WRITE))
        else $error("first sample must not update covariance");
`endif

endmodule

// ===== tb/tb_online_covariance_update.sv =====
// ----------------------------------------------------------------------------
// Online covariance update testbench
// Drives element pairs through the queue-style input, predicts each element's
// running mean and covariance in a local model of the stores, and compares
// every popped result field by field against the oldest predicted one.
// ----------------------------------------------------------------------------
module tb_online_covariance_update;
    timeunit 1ns;
    timeprecision 1ps;
    import ocu_pkg::*;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int DRAIN_CYCLES = 300;

    // Result fields as one record, so that one comparison covers a beat.
    typedef struct {
        logic [IDX_W-1:0] index;
        logic [COV_W-1:0] cov;
        logic [CNT_W-1:0] seen;
        logic             done;
    } t_cov_result;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [LEN_W-1:0]    i_cfg_data;
    logic                push;
    logic                full;
    logic [SAMP_W-1:0]   i_sample_x;
    logic [SAMP_W-1:0]   i_sample_y;
    logic                empty;
    logic                pop;
    logic [IDX_W-1:0]    o_element_index;
    logic [COV_W-1:0]    o_covariance_value;
    logic [CNT_W-1:0]    o_samples_seen;
    logic                o_vector_done;

    online_covariance_update uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_data         (i_cfg_data),
        .push               (push),
        .full               (full),
        .i_sample_x         (i_sample_x),
        .i_sample_y         (i_sample_y),
        .empty              (empty),
        .pop                (pop),
        .o_element_index    (o_element_index),
        .o_covariance_value (o_covariance_value),
        .o_samples_seen     (o_samples_seen),
        .o_vector_done      (o_vector_done)
    );

    // Local copy of the block's state, updated once per accepted beat.
    logic signed [COV_W-1:0]  cov_mem  [MAX_VECTOR];
    logic signed [SAMP_W-1:0] mx_mem   [MAX_VECTOR];
    logic signed [SAMP_W-1:0] my_mem   [MAX_VECTOR];
    logic [CNT_W-1:0]         vec_count;
    logic [IDX_W-1:0]         elem_pos;
    logic [LEN_W-1:0]         len_reg;

    t_cov_result cov_due[$];
    int          mismatches;
    int          cycle_count;

    // Receiver controls: the stall pattern and the long hold-off.
    int   pop_mode;
    logic hold_req;
    logic holding;

    // The clock runs free; the reset is held low from the start of the run.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog. Any run longer than this has hung somewhere.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Receiver: pop follows a pattern chosen by the running test, and goes
    // quiet while a hold-off is in progress.
    always @(posedge i_clk) begin
        if (holding) begin
            pop <= 1'b0;
        end else begin
            case (pop_mode)
                0: pop <= 1'b1;
                1: pop <= ($urandom_range(0, 1) == 0);
                2: pop <= ($urandom_range(0, 7) == 0);
                default: pop <= ((cycle_count % 23) < 5);
            endcase
        end
    end

    // The hold-off counts its own cycles so the sender keeps offering beats
    // while results pile up inside the block.
    initial begin
        holding = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                holding <= 1'b1;
                repeat (3000) @(posedge i_clk);
                holding <= 1'b0;
            end
        end
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch at cycle %0d: %s got %h, wanted %h", cycle_count, what, got,
                 want);
        mismatches++;
    endtask

    // Result checker. Values sampled at the edge are the ones the handshake
    // moved, since every driver uses nonblocking assignments.
    always @(posedge i_clk) begin
        t_cov_result want;
        if (i_rst_n && pop && !empty) begin
            if (cov_due.size() == 0) begin
                report_mismatch("result beat with nothing pending",
                                64'(o_element_index), 64'd0);
            end else begin
                want = cov_due.pop_front();
                if (o_element_index !== want.index)
                    report_mismatch("element_index", 64'(o_element_index),
                                    64'(want.index));
                if (o_covariance_value !== want.cov)
                    report_mismatch("covariance_value", 64'(o_covariance_value),
                                    64'(want.cov));
                if (o_samples_seen !== want.seen)
                    report_mismatch("samples_seen", 64'(o_samples_seen),
                                    64'(want.seen));
                if (o_vector_done !== want.done)
                    report_mismatch("vector_done", 64'(o_vector_done),
                                    64'(want.done));
            end
        end
    end

    // Welford update of one element: new mean x first, the covariance from
    // the new mean x and the old mean y, then the new mean y. The covariance
    // numerator is formed exactly and divided once, truncating toward zero.
    function automatic t_cov_result update_element(input logic [SAMP_W-1:0] xs,
                                                   input logic [SAMP_W-1:0] ys);
        t_cov_result r;
        longint x, y, mx, my, dv;
        logic signed [127:0] num, den, quo, cov_w, dx, dy, m;
        logic [IDX_W-1:0] p;
        int unsigned len;
        logic last;
        x  = longint'($signed(xs));
        y  = longint'($signed(ys));
        dv = longint'({32'd0, vec_count}) + 1;
        len = 32'(len_reg);
        if (len < 1) len = 1;
        if (len > MAX_VECTOR) len = MAX_VECTOR;
        p  = elem_pos;
        mx = longint'(mx_mem[p]);
        my = longint'(my_mem[p]);
        mx = mx + (x - mx) / dv;
        if (vec_count != 0) begin
            m     = 128'(vec_count) - 1;
            cov_w = 128'(cov_mem[p]);
            dx    = 128'(x - mx);
            dy    = 128'(y - my);
            num   = m * cov_w * 65536 + dx * dy;
            den   = 128'(vec_count) << 16;
            quo   = num / den;
            if (quo > 128'($signed(COV_MAX))) cov_mem[p] = COV_MAX;
            else if (quo < 128'($signed(COV_MIN))) cov_mem[p] = COV_MIN;
            else cov_mem[p] = quo[COV_W-1:0];
        end
        my = my + (y - my) / dv;
        mx_mem[p] = mx[SAMP_W-1:0];
        my_mem[p] = my[SAMP_W-1:0];
        last = (int'(p) + 1 >= len);
        r.index = p;
        r.cov   = cov_mem[p];
        r.seen  = (vec_count == '1) ? vec_count : vec_count + CNT_W'(1);
        r.done  = last;
        if (last) begin
            elem_pos  = '0;
            vec_count = r.seen;
        end else begin
            elem_pos = p + IDX_W'(1);
        end
        return r;
    endfunction

    // Send one beat. Push is left high so back-to-back beats need no toggle;
    // the caller lowers it when a gap follows.
    task automatic send_pair(input logic [SAMP_W-1:0] xs, input logic [SAMP_W-1:0] ys);
        push       <= 1'b1;
        i_sample_x <= xs;
        i_sample_y <= ys;
        do @(posedge i_clk); while (full);
        cov_due.push_back(update_element(xs, ys));
    endtask

    task automatic pause_sender(input int cycles);
        push <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        while (cov_due.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // The length register is written only once the block has gone idle.
    task automatic write_length(input logic [LEN_W-1:0] value);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        len_reg = value;
    endtask

    // Sample values: mostly full range, with extremes and small values mixed
    // in so that saturation and near-zero differences both occur.
    function automatic logic [SAMP_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'($signed($urandom_range(0, 2000)) - 1000);
            3: return 32'($urandom_range(0, 255)) << 16;
            default: return $urandom;
        endcase
    endfunction

    // Bursty traffic: random burst lengths with random gaps between them.
    task automatic send_random_bursts(input int count);
        int burst;
        burst = 0;
        repeat (count) begin
            if (burst == 0) begin
                burst = $urandom_range(1, 12);
                if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 40));
            end
            send_pair(pick_sample(), pick_sample());
            burst--;
        end
        push <= 1'b0;
    endtask

    // Directed: extreme samples while the first vector is in progress at the
    // reset length, so the means move and the covariance is left alone.
    task automatic test_first_vector();
        pop_mode = 0;
        send_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_pair(32'h8000_0000, 32'h8000_0000);
        send_pair(32'h7FFF_FFFF, 32'h8000_0000);
        send_pair(32'h0000_0000, 32'h0000_0000);
        send_pair(32'hFFFF_FFFF, 32'h0000_0001);
        send_pair(32'h0001_0000, 32'hFFFF_0000);
    endtask

    // Directed: short vectors with opposite extremes drive the covariance
    // into both saturation limits; the shortest length and the out-of-range
    // value zero are exercised too.
    task automatic test_saturation();
        write_length(11'd2);
        repeat (3) begin
            send_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF);
            send_pair(32'h8000_0000, 32'h7FFF_FFFF);
            send_pair(32'h8000_0000, 32'h8000_0000);
            send_pair(32'h7FFF_FFFF, 32'h8000_0000);
        end
        write_length(11'd0);
        send_pair(32'h8000_0000, 32'h7FFF_FFFF);
        send_pair(32'h7FFF_FFFF, 32'h8000_0000);
        write_length(11'd1);
        send_pair(32'h1234_5678, 32'h8765_4321);
    endtask

    // Directed: the length is cut below the current position mid-vector, so
    // the next element is still processed at its position and closes the
    // vector.
    task automatic test_length_shrink();
        write_length(11'd4);
        send_pair(32'h0002_0000, 32'h0003_0000);
        send_pair(32'hFFFE_0000, 32'h0001_0000);
        send_pair(32'h0000_8000, 32'hFFFF_8000);
        write_length(11'd2);
        send_pair(32'h0005_0000, 32'h0006_0000);
        send_pair(32'h0001_0000, 32'h0001_0000);
    endtask

    // Pressure: the receiver holds off for a long stretch while the sender
    // keeps offering beats, so the block fills and lowers full only later.
    task automatic test_backpressure();
        write_length(11'd3);
        hold_req <= 1'b1;
        @(posedge i_clk);
        hold_req <= 1'b0;
        repeat (40) send_pair(pick_sample(), pick_sample());
        push <= 1'b0;
    endtask

    // Random phases over several lengths, the extremes among them, with the
    // receiver pattern changed for each phase.
    task automatic test_random_phases();
        logic [LEN_W-1:0] lens[10] = '{11'd1, 11'd3, 11'd8, 11'd2, 11'd2047, 11'd5,
                                      11'd1024, 11'd0, 11'd7, 11'd4};
        for (int i = 0; i < 10; i++) begin
            write_length(lens[i]);
            pop_mode = $urandom_range(0, 3);
            send_random_bursts(120);
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        push        = 1'b0;
        i_sample_x  = '0;
        i_sample_y  = '0;
        pop         = 1'b0;
        pop_mode    = 0;
        hold_req    = 1'b0;
        mismatches  = 0;
        cycle_count = 0;
        vec_count   = '0;
        elem_pos    = '0;
        len_reg     = 11'd1024;
        for (int i = 0; i < MAX_VECTOR; i++) begin
            cov_mem[i] = '0;
            mx_mem[i]  = '0;
            my_mem[i]  = '0;
        end
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_first_vector();
        test_saturation();
        test_length_shrink();
        test_backpressure();
        test_random_phases();

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && cov_due.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
